// ===== hdl/kdlp_pkg.sv =====
// Package for the key debouncer with short and long press reporting.
// Holds the field widths, operation and press-kind codes, the configuration
// type and the key encoder. It depends on nothing else.
package kdlp_pkg;

	localparam int unsigned KEY_LINES_W = 4;
	localparam int unsigned KEY_CODE_W  = 3;
	localparam int unsigned THRESH_W    = 16;
	localparam int unsigned LIMIT_W     = 4;
	localparam int unsigned TICKS_W     = 16;
	localparam int unsigned CFG_IDX_W   = 1;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd100;
	localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 4'd3;
	localparam logic [TICKS_W-1:0]  TICKS_MAX    = 16'hFFFF;

	localparam logic [KEY_CODE_W-1:0] NO_KEY = 3'd0;

	// Operation carried by an input item.
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 1'b1;

	typedef enum logic [2:0] {
		KIND_NONE  = 3'b001,
		KIND_SHORT = 3'b010,
		KIND_LONG  = 3'b100
	} kind_t;

	typedef struct packed {
		logic [THRESH_W-1:0] threshold;
		logic [LIMIT_W-1:0]  limit;
	} cfg_t;

	// Active-low lines, lowest-numbered key wins; 0 means no key down.
	function automatic logic [KEY_CODE_W-1:0] encode_lines(
		input logic [KEY_LINES_W-1:0] lines
	);
		logic [KEY_CODE_W-1:0] code;
		code = NO_KEY;
		if (!lines[0]) begin
			code = 3'd1;
		end else if (!lines[1]) begin
			code = 3'd2;
		end else if (!lines[2]) begin
			code = 3'd3;
		end else if (!lines[3]) begin
			code = 3'd4;
		end
		return code;
	endfunction

endpackage

// ===== hdl/kdlp_cfg.sv =====
// Configuration registers of the key debouncer: long-press threshold and
// debounce limit. Depends on kdlp_pkg.
module kdlp_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [kdlp_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [kdlp_pkg::CFG_DATA_W-1:0] wr_data,
	output kdlp_pkg::cfg_t                  cfg
);

	logic [kdlp_pkg::THRESH_W-1:0] threshold_q;
	logic [kdlp_pkg::LIMIT_W-1:0]  limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= kdlp_pkg::THRESH_RESET;
			limit_q     <= kdlp_pkg::LIMIT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				kdlp_pkg::REG_THRESHOLD: threshold_q <= wr_data[kdlp_pkg::THRESH_W-1:0];
				kdlp_pkg::REG_LIMIT:     limit_q     <= wr_data[kdlp_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.threshold = threshold_q;
	assign cfg.limit     = limit_q;

endmodule

// ===== hdl/kdlp_core.sv =====
// Debounce and press-tracking state with its next-state logic; produces the
// report for a read item. Depends on kdlp_pkg.
module kdlp_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step,
	input  logic                             op,
	input  logic [kdlp_pkg::KEY_LINES_W-1:0] key_lines,
	input  kdlp_pkg::cfg_t                   cfg,
	output logic [kdlp_pkg::KEY_CODE_W-1:0]  key_code,
	output logic                             long_flag
);

	logic [kdlp_pkg::KEY_CODE_W-1:0] last_sample_q, last_sample_d;
	logic [kdlp_pkg::LIMIT_W-1:0]    stable_count_q, stable_count_d;
	logic                            held_q, held_d;
	logic                            reported_q, reported_d;
	logic                            released_q, released_d;
	logic [kdlp_pkg::KEY_CODE_W-1:0] captured_key_q, captured_key_d;
	kdlp_pkg::kind_t                 kind_q, kind_d;
	logic [kdlp_pkg::TICKS_W-1:0]    ticks_q, ticks_d;

	logic [kdlp_pkg::KEY_CODE_W-1:0] cur;
	logic [kdlp_pkg::TICKS_W-1:0]    ticks_inc;

	assign cur       = kdlp_pkg::encode_lines(key_lines);
	assign ticks_inc = (ticks_q != kdlp_pkg::TICKS_MAX) ? ticks_q + 1'b1 : ticks_q;

	always_comb begin
		last_sample_d  = last_sample_q;
		stable_count_d = stable_count_q;
		held_d         = held_q;
		reported_d     = reported_q;
		released_d     = released_q;
		captured_key_d = captured_key_q;
		kind_d         = kind_q;
		ticks_d        = ticks_q;
		key_code       = kdlp_pkg::NO_KEY;
		long_flag      = 1'b0;

		if (op == kdlp_pkg::OP_TICK) begin
			if (cur != last_sample_q) begin
				last_sample_d  = cur;
				stable_count_d = '0;
			end else if (stable_count_q < cfg.limit) begin
				stable_count_d = stable_count_q + 1'b1;
			end else if (cur != kdlp_pkg::NO_KEY) begin
				if (!held_q) begin
					// A new press keeps any release that is still waiting to be read.
					held_d         = 1'b1;
					reported_d     = 1'b0;
					captured_key_d = cur;
					kind_d         = kdlp_pkg::KIND_SHORT;
					ticks_d        = '0;
				end else begin
					ticks_d = ticks_inc;
					if (ticks_inc >= cfg.threshold) begin
						kind_d = kdlp_pkg::KIND_LONG;
					end
				end
			end else if (held_q) begin
				held_d     = 1'b0;
				released_d = 1'b1;
			end
		end else begin
			if (kind_q == kdlp_pkg::KIND_LONG && !reported_q) begin
				key_code   = captured_key_q;
				long_flag  = 1'b1;
				reported_d = 1'b1;
			end else if (kind_q == kdlp_pkg::KIND_SHORT && released_q && !reported_q) begin
				key_code   = captured_key_q;
				reported_d = 1'b1;
			end
			if (reported_d && released_q) begin
				captured_key_d = kdlp_pkg::NO_KEY;
				kind_d         = kdlp_pkg::KIND_NONE;
				ticks_d        = '0;
				released_d     = 1'b0;
				reported_d     = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sample_q  <= kdlp_pkg::NO_KEY;
			stable_count_q <= '0;
			held_q         <= 1'b0;
			reported_q     <= 1'b0;
			released_q     <= 1'b0;
			captured_key_q <= kdlp_pkg::NO_KEY;
			kind_q         <= kdlp_pkg::KIND_NONE;
			ticks_q        <= '0;
		end else if (step) begin
			last_sample_q  <= last_sample_d;
			stable_count_q <= stable_count_d;
			held_q         <= held_d;
			reported_q     <= reported_d;
			released_q     <= released_d;
			captured_key_q <= captured_key_d;
			kind_q         <= kind_d;
			ticks_q        <= ticks_d;
		end
	end

	// With no press on record the captured key is clear.
	a_idle_key: assert property (@(posedge clk) disable iff (!arst_n)
		(kind_q == kdlp_pkg::KIND_NONE) |-> (captured_key_q == kdlp_pkg::NO_KEY))
		else $error("captured key set with no press on record");

	a_kind_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(kind_q))
		else $error("press kind is not a valid one-hot code");

	a_tick_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(op == kdlp_pkg::OP_TICK) |-> (key_code == kdlp_pkg::NO_KEY && !long_flag))
		else $error("report driven for a scan tick");

endmodule

// ===== hdl/key_debounce_long_press_top.sv =====
// A read item waits in the input register; its result is then captured in the output register.
// Throughput: one item per cycle; the input register stalls only while it holds a read and a result waits.
// Reset (arst_n low) clears all debounce and press state, empties both registers,
// and sets the threshold to 100 ticks and the debounce limit to 3.
// Top level of the key debouncer; depends on kdlp_pkg, kdlp_cfg and kdlp_core.
module key_debounce_long_press_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             opcode,
	input  logic [kdlp_pkg::KEY_LINES_W-1:0] key_lines,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [kdlp_pkg::KEY_CODE_W-1:0]  key_code,
	output logic                             long_flag,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [kdlp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kdlp_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic                             valid_s1;
	logic                             op_s1;
	logic [kdlp_pkg::KEY_LINES_W-1:0] lines_s1;
	logic                             adv_s1;
	logic                             out_free;
	logic [kdlp_pkg::KEY_CODE_W-1:0]  code_c;
	logic                             long_c;
	logic [kdlp_pkg::KEY_CODE_W-1:0]  key_code_q;
	logic                             long_flag_q;
	logic                             out_valid_q;
	kdlp_pkg::cfg_t                   cfg;

	assign cfg_ready = 1'b1;

	kdlp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// A tick never needs the output register; a read needs it free or draining.
	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && (op_s1 == kdlp_pkg::OP_TICK || out_free);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1    <= opcode;
			lines_s1 <= key_lines;
		end
	end

	kdlp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv_s1),
		.op        (op_s1),
		.key_lines (lines_s1),
		.cfg       (cfg),
		.key_code  (code_c),
		.long_flag (long_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && op_s1 == kdlp_pkg::OP_READ) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && op_s1 == kdlp_pkg::OP_READ) begin
			key_code_q  <= code_c;
			long_flag_q <= long_c;
		end
	end

	assign out_valid = out_valid_q;
	assign key_code  = key_code_q;
	assign long_flag = long_flag_q;

	// A result only ever comes from a read item leaving the input register.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv_s1 && op_s1 == kdlp_pkg::OP_READ))
		else $error("result appeared without a read transfer");

	// A read facing an empty output register always gets through.
	a_read_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && op_s1 == kdlp_pkg::OP_READ && !out_valid_q) |=> out_valid_q)
		else $error("read stalled with output register empty");

	a_tick_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && op_s1 == kdlp_pkg::OP_TICK) |-> in_ready)
		else $error("scan tick stalled the input register");

endmodule

// ===== tb/tb_key_debounce_long_press_top.sv =====
// Self-checking testbench for the four-key debouncer with short and long press reporting.
// Drives ticks, reads and register writes over valid/ready and checks every report
// against its own model of the press state. Depends on kdlp_pkg and key_debounce_long_press_top.
module tb_key_debounce_long_press_top;

	localparam int unsigned STALL_LIMIT  = 1000;
	localparam int unsigned RANDOM_ITEMS = 1750;

	localparam logic [kdlp_pkg::KEY_CODE_W-1:0] KEY1 = 3'd1;
	localparam logic [kdlp_pkg::KEY_CODE_W-1:0] KEY2 = 3'd2;
	localparam logic [kdlp_pkg::KEY_CODE_W-1:0] KEY3 = 3'd3;
	localparam logic [kdlp_pkg::KEY_CODE_W-1:0] KEY4 = 3'd4;

	localparam logic [kdlp_pkg::KEY_LINES_W-1:0] LINES_UP = 4'b1111;

	typedef struct packed {
		logic [kdlp_pkg::KEY_CODE_W-1:0] code;
		logic                            long_press;
	} report_t;

	logic                              clk       = 1'b0;
	logic                              arst_n    = 1'b0;
	logic                              in_valid  = 1'b0;
	logic                              in_ready;
	logic                              opcode    = kdlp_pkg::OP_TICK;
	logic [kdlp_pkg::KEY_LINES_W-1:0]  key_lines = LINES_UP;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic [kdlp_pkg::KEY_CODE_W-1:0]   key_code;
	logic                              long_flag;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [kdlp_pkg::CFG_IDX_W-1:0]    cfg_index = kdlp_pkg::REG_THRESHOLD;
	logic [kdlp_pkg::CFG_DATA_W-1:0]   cfg_data  = '0;

	// Model of the press tracker.
	logic [kdlp_pkg::THRESH_W-1:0]     cur_threshold  = kdlp_pkg::THRESH_RESET;
	logic [kdlp_pkg::LIMIT_W-1:0]      cur_limit      = kdlp_pkg::LIMIT_RESET;
	logic [kdlp_pkg::KEY_CODE_W-1:0]   seen_key       = kdlp_pkg::NO_KEY;
	logic [kdlp_pkg::LIMIT_W-1:0]      same_count     = '0;
	logic                              press_held     = 1'b0;
	logic                              press_reported = 1'b0;
	logic                              press_released = 1'b0;
	logic [kdlp_pkg::KEY_CODE_W-1:0]   press_key      = kdlp_pkg::NO_KEY;
	kdlp_pkg::kind_t                   press_kind     = kdlp_pkg::KIND_NONE;
	logic [kdlp_pkg::TICKS_W-1:0]      hold_count     = '0;

	report_t pending_reports[$];

	bit          steady = 1'b0;
	int unsigned items_sent, reads_sent, reports_checked, long_reports;
	int unsigned fail_count, quiet_cycles;

	key_debounce_long_press_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.key_lines (key_lines),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.key_code  (key_code),
		.long_flag (long_flag),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 7);
	end

	function automatic logic [kdlp_pkg::KEY_CODE_W-1:0] lowest_key_down(
		input logic [kdlp_pkg::KEY_LINES_W-1:0] lines
	);
		casez (lines)
			4'b???0: return KEY1;
			4'b??01: return KEY2;
			4'b?011: return KEY3;
			4'b0111: return KEY4;
			default: return kdlp_pkg::NO_KEY;
		endcase
	endfunction

	task automatic track_tick(input logic [kdlp_pkg::KEY_LINES_W-1:0] lines);
		logic [kdlp_pkg::KEY_CODE_W-1:0] cur;
		cur = lowest_key_down(lines);
		if (cur != seen_key) begin
			seen_key   = cur;
			same_count = '0;
		end else if (same_count < cur_limit) begin
			same_count = same_count + 1'b1;
		end else if (cur != kdlp_pkg::NO_KEY) begin
			if (!press_held) begin
				press_held     = 1'b1;
				press_reported = 1'b0;
				press_key      = cur;
				press_kind     = kdlp_pkg::KIND_SHORT;
				hold_count     = '0;
			end else begin
				if (hold_count != kdlp_pkg::TICKS_MAX) hold_count = hold_count + 1'b1;
				if (hold_count >= cur_threshold) press_kind = kdlp_pkg::KIND_LONG;
			end
		end else if (press_held) begin
			press_held     = 1'b0;
			press_released = 1'b1;
		end
	endtask

	task automatic track_read();
		report_t r;
		r.code       = kdlp_pkg::NO_KEY;
		r.long_press = 1'b0;
		if (press_kind == kdlp_pkg::KIND_LONG && !press_reported) begin
			r.code         = press_key;
			r.long_press   = 1'b1;
			press_reported = 1'b1;
		end else if (press_kind == kdlp_pkg::KIND_SHORT && press_released
				&& !press_reported) begin
			r.code         = press_key;
			press_reported = 1'b1;
		end
		// The press is forgotten only once it has been both reported and released.
		if (press_reported && press_released) begin
			press_key      = kdlp_pkg::NO_KEY;
			press_kind     = kdlp_pkg::KIND_NONE;
			hold_count     = '0;
			press_released = 1'b0;
			press_reported = 1'b0;
		end
		pending_reports.push_back(r);
	endtask

	task automatic send_item(input logic op, input logic [kdlp_pkg::KEY_LINES_W-1:0] lines);
		int gap;
		gap = 0;
		if (!steady && $urandom_range(99) < 7) gap = $urandom_range(3, 1);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		opcode    <= op;
		key_lines <= lines;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		if (op == kdlp_pkg::OP_TICK) begin
			track_tick(lines);
		end else begin
			reads_sent++;
			track_read();
		end
	endtask

	task automatic ticks(input logic [kdlp_pkg::KEY_LINES_W-1:0] lines, input int count);
		repeat (count) send_item(kdlp_pkg::OP_TICK, lines);
	endtask

	task automatic read_report();
		send_item(kdlp_pkg::OP_READ, 4'($urandom));
	endtask

	// Ticks give no result, so the wait runs on past the last report.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(
		input logic [kdlp_pkg::CFG_IDX_W-1:0]  idx,
		input logic [kdlp_pkg::CFG_DATA_W-1:0] data
	);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == kdlp_pkg::REG_THRESHOLD) begin
			cur_threshold = data[kdlp_pkg::THRESH_W-1:0];
		end else if (idx == kdlp_pkg::REG_LIMIT) begin
			cur_limit = data[kdlp_pkg::LIMIT_W-1:0];
		end
	endtask

	always @(posedge clk) begin : check_results
		report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected report key_code=%0d long_flag=%0b",
					$time, key_code, long_flag);
				fail_count++;
			end else begin
				want = pending_reports.pop_front();
				reports_checked++;
				if (want.long_press) long_reports++;
				if (key_code !== want.code) begin
					$display("%0t: key_code mismatch, expected %0d, got %0d",
						$time, want.code, key_code);
					fail_count++;
				end
				if (long_flag !== want.long_press) begin
					$display("%0t: long_flag mismatch, expected %0b, got %0b",
						$time, want.long_press, long_flag);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Reset values: debounce limit 3 and threshold 100 decide when the long press appears.
	task automatic test_reset_defaults();
		read_report();
		ticks(4'b1101, 104);
		read_report();
		ticks(4'b1101, 1);
		read_report();
		ticks(LINES_UP, 5);
		read_report();
		read_report();
	endtask

	task automatic test_key_priority();
		logic [kdlp_pkg::KEY_LINES_W-1:0] patterns [6];
		patterns = '{4'b1110, 4'b1101, 4'b1011, 4'b0111, 4'b0000, 4'b0101};
		write_reg(kdlp_pkg::REG_LIMIT, '0);
		write_reg(kdlp_pkg::REG_THRESHOLD, 16'hFFFF);
		foreach (patterns[i]) begin
			ticks(patterns[i], 2);
			ticks(LINES_UP, 2);
			read_report();
		end
	endtask

	// With a zero threshold the press turns long on the first held tick after it begins.
	task automatic test_threshold_zero();
		write_reg(kdlp_pkg::REG_THRESHOLD, '0);
		ticks(4'b1101, 2);
		read_report();
		ticks(4'b1101, 1);
		read_report();
		read_report();
		ticks(LINES_UP, 2);
		read_report();
		read_report();
	endtask

	task automatic test_key_change_while_held();
		write_reg(kdlp_pkg::REG_THRESHOLD, 16'd3);
		ticks(4'b1011, 2);
		ticks(4'b1110, 4);
		read_report();
		ticks(LINES_UP, 2);
		read_report();
	endtask

	// A second press starts before the first release has been read out.
	task automatic test_new_press_before_read();
		ticks(4'b1110, 2);
		ticks(LINES_UP, 2);
		ticks(4'b0111, 2);
		read_report();
		read_report();
		ticks(LINES_UP, 2);
		read_report();
	endtask

	// The limit drops under the running count, and its upper data bits are ignored.
	task automatic test_limit_lowered();
		write_reg(kdlp_pkg::REG_LIMIT, 16'd15);
		ticks(4'b1110, 13);
		write_reg(kdlp_pkg::REG_LIMIT, 16'hFFF2);
		ticks(4'b1110, 1);
		read_report();
		ticks(LINES_UP, 4);
		read_report();
	endtask

	task automatic noisy_tick(inout logic [kdlp_pkg::KEY_LINES_W-1:0] down);
		int r;
		r = $urandom_range(99);
		if (r < 14) begin
			read_report();
		end else if (r < 19) begin
			send_item(kdlp_pkg::OP_TICK, 4'($urandom));
		end else begin
			if (r < 21) down = ~(4'b0001 << $urandom_range(3));
			send_item(kdlp_pkg::OP_TICK, down);
		end
	endtask

	task automatic run_press();
		logic [kdlp_pkg::KEY_LINES_W-1:0] down;
		logic [kdlp_pkg::KEY_LINES_W-1:0] up;
		int r, span, hold;
		r = $urandom_range(99);
		if (r < 70) begin
			down = ~(4'b0001 << $urandom_range(3));
		end else if (r < 90) begin
			down = 4'($urandom);
		end else begin
			down = LINES_UP;
		end
		span = (cur_threshold < 36) ? int'(cur_threshold) + 4 : 40;
		hold = int'(cur_limit) + 1 + $urandom_range(span);
		repeat (hold) noisy_tick(down);
		up = LINES_UP;
		repeat (int'(cur_limit) + 1 + $urandom_range(3)) noisy_tick(up);
		if ($urandom_range(99) < 60) read_report();
	endtask

	task automatic test_random_presses();
		int unsigned start;
		start = items_sent;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					write_reg(kdlp_pkg::REG_THRESHOLD, 16'd1);
					write_reg(kdlp_pkg::REG_LIMIT, '0);
				end
				1: begin
					write_reg(kdlp_pkg::REG_THRESHOLD, 16'($urandom_range(30, 2)));
					write_reg(kdlp_pkg::REG_LIMIT, 16'($urandom_range(5)));
				end
				2: begin
					write_reg(kdlp_pkg::REG_THRESHOLD, '0);
					write_reg(kdlp_pkg::REG_LIMIT, 16'd15);
				end
				3: begin
					write_reg(kdlp_pkg::REG_THRESHOLD, 16'($urandom_range(12, 1)));
					write_reg(kdlp_pkg::REG_LIMIT, 16'd1);
				end
				4: begin
					write_reg(kdlp_pkg::REG_THRESHOLD, 16'hFFFF);
					write_reg(kdlp_pkg::REG_LIMIT, 16'($urandom));
				end
				default: begin
					write_reg(kdlp_pkg::REG_THRESHOLD, 16'($urandom_range(20, 1)));
					write_reg(kdlp_pkg::REG_LIMIT, '0);
				end
			endcase
			// One phase runs with neither side idling.
			steady = (phase == 3);
			while (items_sent - start < (phase + 1) * RANDOM_ITEMS / 6) run_press();
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_key_priority();
		test_threshold_zero();
		test_key_change_while_held();
		test_new_press_before_read();
		test_limit_lowered();
		test_random_presses();
		wait_idle();
		repeat (8) @(posedge clk);
		$display("Sent %0d items (%0d reads) across directed cases and random press sequences,",
			items_sent, reads_sent);
		$display("under changing thresholds and limits; %0d reports checked, %0d long presses.",
			reports_checked, long_reports);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/kdlp_pkg.sv
hdl/kdlp_cfg.sv
hdl/kdlp_core.sv
hdl/key_debounce_long_press_top.sv
tb/tb_key_debounce_long_press_top.sv
